// ----- rtl/aes_block_encrypt_assert.svh -----
// Assertion macros used by the checker file
`ifndef AES_BLOCK_ENCRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_ASSERT_SVH

// Checks that an implication holds on every clock edge out of reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/aesbe_pkg.sv -----
package aesbe_pkg;

    localparam int MAX_ROUNDS_DEF = 14;
    localparam int NUM_REGS       = 5;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd4;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;
    // mode three runs as a 256-bit key
    localparam logic [1:0] MODE_ODD = 2'd3;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_item_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // SubBytes + ShiftRows, byte 0 in bits 127:120
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(c*4+r) -: 8] = sbox(s[127-8*(((c+r)%4)*4+r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

// ----- rtl/aes_block_encrypt.sv -----
// Each block passes through the chain of registered round cells, input to result.
// Throughput: one block per cycle while no key rebuild runs and no held result stalls.
// A write to the mode or a key register stalls the input while the schedule rebuilds.
// Reset clears all valid flags and builds the schedule of the all-zero 128-bit key;
// the input stalls while that runs.
module aes_block_encrypt #(
    parameter int MAX_ROUNDS = aesbe_pkg::MAX_ROUNDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  aesbe_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output aesbe_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [aesbe_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [63:0]          cfg_data
);
    logic [1:0]  mode_reg;
    logic [63:0] k_reg [4];
    logic        restart;
    logic [(MAX_ROUNDS+1)*128-1:0] rk;
    logic [3:0]  nr;
    logic        ks_busy;
    logic        en;
    logic [127:0] st [MAX_ROUNDS+1];
    logic         v [MAX_ROUNDS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= aesbe_pkg::MODE_128;
            for (int i = 0; i < 4; i++) k_reg[i] <= 64'h0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                aesbe_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                aesbe_pkg::REG_KEY0: k_reg[0] <= cfg_data;
                aesbe_pkg::REG_KEY1: k_reg[1] <= cfg_data;
                aesbe_pkg::REG_KEY2: k_reg[2] <= cfg_data;
                aesbe_pkg::REG_KEY3: k_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // the expander restarts the cycle after a valid write lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) restart <= 1'b0;
        else restart <= cfg_we && (cfg_idx < 3'(aesbe_pkg::NUM_REGS));
    end

    aesbe_key_sched #(.MAX_ROUNDS(MAX_ROUNDS)) u_ks (
        .clk(clk), .rst_n(rst_n), .restart(restart), .mode(mode_reg),
        .key({k_reg[0], k_reg[1], k_reg[2], k_reg[3]}),
        .round_keys(rk), .nr(nr), .busy(ks_busy)
    );

    // chain stalls only while a finished result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en || ks_busy;

    assign st[0] = {in_data.plain_high, in_data.plain_low}
                   ^ rk[(MAX_ROUNDS+1)*128-1 -: 128];
    assign v[0]  = in_valid && !ks_busy;

    for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
        aesbe_round_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(v[r-1]),
            .mix(4'(r) < nr),
            .pass(4'(r) > nr),
            .state_in(st[r-1]),
            .rkey(rk[(MAX_ROUNDS+1-r)*128-1 -: 128]),
            .valid_out(v[r]),
            .state_out(st[r])
        );
    end

    assign out_valid = v[MAX_ROUNDS];
    assign out_data  = {st[MAX_ROUNDS][127:64], st[MAX_ROUNDS][63:0]};
endmodule

// ----- rtl/aesbe_key_sched.sv -----
// Key expansion: one 32-bit word a cycle into a register file of round keys.
// Restarts on every write to a configuration register; busy stays high until the schedule settles.
module aesbe_key_sched #(
    parameter int MAX_ROUNDS = aesbe_pkg::MAX_ROUNDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                restart,
    input  logic [1:0]                          mode,
    input  logic [255:0]                        key,
    output logic [(MAX_ROUNDS+1)*128-1:0]       round_keys,
    output logic [3:0]                          nr,
    output logic                                busy
);
    localparam int NW = 4 * (MAX_ROUNDS + 1);

    logic [31:0] w_reg [NW];
    logic [31:0] win_reg [8];   // newest word first
    logic [5:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [2:0]  pos_reg, pos_next;   // idx mod nk
    logic [3:0]  nk, nr_full;
    logic [5:0]  total;
    logic [31:0] t, wnew, prev, back;
    logic [1:0]  m;

    assign m       = (mode == aesbe_pkg::MODE_ODD) ? aesbe_pkg::MODE_256 : mode;
    assign nk      = 4'(4 + 2 * m);
    assign nr_full = 4'(10 + 2 * m);
    assign nr      = (nr_full > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : nr_full;
    assign total   = 6'(4 * (nr + 1));

    // prior words come from a short window of the last eight
    assign prev = win_reg[0];
    assign back = win_reg[3'(nk - 4'd1)];
    assign busy = busy_reg || restart;

    always_comb
    begin
        t = prev;
        rcon_next = rcon_reg;
        if (pos_reg == 3'd0) begin
            t = aesbe_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
            rcon_next = aesbe_pkg::xtime(rcon_reg);
        end else if (nk > 4'd6 && pos_reg == 3'd4) begin
            t = aesbe_pkg::sub_word(prev);
        end
        wnew = (idx_reg < 6'(nk)) ? key[255-32*idx_reg[2:0] -: 32] : back ^ t;
        if (idx_reg < 6'(nk)) rcon_next = rcon_reg;
        idx_next  = idx_reg + 6'd1;
        pos_next  = (pos_reg == 3'(nk - 4'd1)) ? 3'd0 : pos_reg + 3'd1;
        busy_next = busy_reg && (idx_next < total);
        if (restart) begin
            idx_next = 6'd0; pos_next = 3'd0; rcon_next = 8'h01; busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= 6'd0; pos_reg <= 3'd0; rcon_reg <= 8'h01; busy_reg <= 1'b1;
        end else begin
            idx_reg <= idx_next; pos_reg <= pos_next;
            rcon_reg <= rcon_next; busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart) begin
            w_reg[idx_reg] <= wnew;
            win_reg[0] <= wnew;
            for (int i = 1; i < 8; i++) win_reg[i] <= win_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NW; i++) begin
            round_keys[(MAX_ROUNDS+1)*128-1-32*i -: 32] = w_reg[i];
        end
    end
endmodule

// ----- rtl/aesbe_round_cell.sv -----
// One round cell: registers the state after one AES round, or passes it through unchanged when pass is set.
module aesbe_round_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         valid_in,
    input  logic         mix,
    input  logic         pass,
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    output logic         valid_out,
    output logic [127:0] state_out
);
    logic [127:0] ss, st_next, st_reg;
    logic         v_reg;

    always_comb
    begin
        ss = aesbe_pkg::sub_shift(state_in);
        if (mix) ss = aesbe_pkg::mix_columns(ss);
        st_next = pass ? state_in : (ss ^ rkey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= 1'b0;
        else if (en) v_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en) st_reg <= st_next;
    end

    assign valid_out = v_reg;
    assign state_out = st_reg;
endmodule

// ----- rtl/aesbe_checker.sv -----
`include "aes_block_encrypt_assert.svh"
module aesbe_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [127:0] out_data
);
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `AES_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
    `AES_ASSERT_IMPL(a_full_stalls_input, clk, rst_n, out_valid && out_stall, in_stall)
endmodule

bind aes_block_encrypt aesbe_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- tb/aes_block_encrypt_test.sv -----
module aes_block_encrypt_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS_MAX  = aesbe_pkg::MAX_ROUNDS_DEF;
    localparam int REBUILD_WAIT = 4 * (ROUNDS_MAX + 1) + 20;
    localparam int DRAIN_WAIT   = ROUNDS_MAX + 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    aesbe_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_stall;
    aesbe_pkg::out_item_t out_data;
    logic        cfg_we;
    logic [aesbe_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [63:0] cfg_data;

    aes_block_encrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    // directed rows: optional rekey, one block, optional literal ciphertext
    typedef struct packed {
        bit         rekey;
        bit [1:0]   mode;
        bit [255:0] key;
        bit [127:0] plain;
        bit         literal;
        bit [127:0] cipher;
    } dir_row_t;

    localparam bit [255:0] KEY_SEQ  =
        256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
    localparam bit [255:0] KEY_ONES = {256{1'b1}};
    localparam bit [127:0] PT_FIPS  = 128'h00112233445566778899aabbccddeeff;
    localparam bit [127:0] PT_ONES  = {128{1'b1}};

    dir_row_t dir_rows [12] = '{
        '{1'b0, aesbe_pkg::MODE_128, 256'h0, 128'h0,
          1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{1'b0, aesbe_pkg::MODE_128, 256'h0, PT_ONES, 1'b0, 128'h0},
        // lower key words hold junk that a 128-bit key must ignore
        '{1'b1, aesbe_pkg::MODE_128,
          {KEY_SEQ[255:128], 128'hdeadbeef_cafef00d_0123_4567_89ab_cdef},
          PT_FIPS, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{1'b1, aesbe_pkg::MODE_192, {KEY_SEQ[255:64], 64'hffff_0000_ffff_0000},
          PT_FIPS, 1'b1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
        '{1'b1, aesbe_pkg::MODE_256, KEY_SEQ, PT_FIPS,
          1'b1, 128'h8ea2b7ca516745bfeafc49904b496089},
        // mode three behaves as a 256-bit key
        '{1'b1, aesbe_pkg::MODE_ODD, KEY_SEQ, PT_FIPS,
          1'b1, 128'h8ea2b7ca516745bfeafc49904b496089},
        '{1'b0, aesbe_pkg::MODE_ODD, KEY_SEQ, 128'h0, 1'b0, 128'h0},
        '{1'b1, aesbe_pkg::MODE_256, KEY_ONES, 128'h0, 1'b0, 128'h0},
        '{1'b0, aesbe_pkg::MODE_256, KEY_ONES, PT_ONES, 1'b0, 128'h0},
        '{1'b1, aesbe_pkg::MODE_128, KEY_ONES, PT_ONES, 1'b0, 128'h0},
        '{1'b1, aesbe_pkg::MODE_192, KEY_ONES, 128'h0, 1'b0, 128'h0},
        '{1'b1, aesbe_pkg::MODE_128, 256'h0, 128'h0,
          1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e}
    };

    // predictor state
    logic [7:0]  sb [256];
    logic [1:0]  key_mode;
    logic [63:0] key_reg [4];
    logic [63:0] sched [2*(ROUNDS_MAX+1)];
    int          num_rounds;

    aesbe_pkg::out_item_t cipher_q [$];
    int unsigned errors;
    int unsigned blocks_sent;
    int unsigned blocks_seen;
    int unsigned key_loads;
    bit          calm;

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // S-box from the field inverse and the affine map
    function automatic void build_sbox();
        logic [7:0] inv;
        logic [7:0] b;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, a[7:0]);
            if (a == 0) inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[a] = b;
        end
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        int m, nk, total;
        m = (key_mode == aesbe_pkg::MODE_ODD) ? 2 : int'(key_mode);
        nk = 4 + 2 * m;
        num_rounds = 10 + 2 * m;
        if (num_rounds > ROUNDS_MAX) num_rounds = ROUNDS_MAX;
        total = 4 * (num_rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < 60; i++) w[i] = 32'h0;
        for (int i = 0; i < total; i++) begin
            if (i < nk) begin
                w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
            end else begin
                t = w[i-1];
                if (i % nk == 0) begin
                    t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gf_mul(rc, 8'h02);
                end else if (nk > 6 && i % nk == 4) begin
                    t = sbox_word(t);
                end
                w[i] = w[i-nk] ^ t;
            end
        end
        for (int j = 0; j < 2*(ROUNDS_MAX+1); j++) sched[j] = 64'h0;
        for (int i = 0; i + 1 < total; i += 2) sched[i/2] = {w[i], w[i+1]};
    endfunction

    function automatic void write_model_reg(logic [aesbe_pkg::CFG_IDX_W-1:0] idx,
                                            logic [63:0] val);
        case (idx)
            aesbe_pkg::REG_MODE: key_mode = val[1:0];
            aesbe_pkg::REG_KEY0: key_reg[0] = val;
            aesbe_pkg::REG_KEY1: key_reg[1] = val;
            aesbe_pkg::REG_KEY2: key_reg[2] = val;
            aesbe_pkg::REG_KEY3: key_reg[3] = val;
            default:  return;
        endcase
        expand_schedule();
    endfunction

    function automatic logic [127:0] sub_and_shift(logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(c*4+r) -: 8] = sb[s[127-8*(((c+r)%4)*4+r) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix_state(logic [127:0] s);
        logic [127:0] t;
        logic [7:0] b [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) b[r] = s[127-8*(4*c+r) -: 8];
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = gf_mul(b[r], 8'h02) ^ gf_mul(b[(r+1)%4], 8'h03)
                                        ^ b[(r+2)%4] ^ b[(r+3)%4];
        end
        return t;
    endfunction

    function automatic logic [127:0] encrypt_block(logic [127:0] p);
        logic [127:0] s;
        s = p ^ {sched[0], sched[1]};
        for (int r = 1; r < num_rounds; r++)
            s = mix_state(sub_and_shift(s)) ^ {sched[2*r], sched[2*r+1]};
        s = sub_and_shift(s) ^ {sched[2*num_rounds], sched[2*num_rounds+1]};
        return s;
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // result checker and receiver stall bursts
    int stall_left;
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            blocks_seen++;
            if (cipher_q.size() == 0) begin
                $error("unexpected result: cipher_high %h cipher_low %h",
                       out_data.cipher_high, out_data.cipher_low);
                errors++;
            end else begin
                if (out_data.cipher_high !== cipher_q[0].cipher_high) begin
                    $error("cipher_high expected %h actual %h",
                           cipher_q[0].cipher_high, out_data.cipher_high);
                    errors++;
                end
                if (out_data.cipher_low !== cipher_q[0].cipher_low) begin
                    $error("cipher_low expected %h actual %h",
                           cipher_q[0].cipher_low, out_data.cipher_low);
                    errors++;
                end
                void'(cipher_q.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (cipher_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(logic [aesbe_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        write_model_reg(idx, val);
    endtask

    task automatic load_key(logic [1:0] mode, logic [255:0] key);
        logic [aesbe_pkg::CFG_IDX_W-1:0] junk_idx;
        logic [63:0] junk_val;
        wait_drained();
        junk_val = {$urandom, $urandom};
        cfg_write(aesbe_pkg::REG_MODE, {junk_val[63:2], mode});
        cfg_write(aesbe_pkg::REG_KEY0, key[255:192]);
        cfg_write(aesbe_pkg::REG_KEY1, key[191:128]);
        cfg_write(aesbe_pkg::REG_KEY2, key[127:64]);
        cfg_write(aesbe_pkg::REG_KEY3, key[63:0]);
        // an index past the last register must leave the schedule alone
        junk_idx = 3'($urandom_range(aesbe_pkg::NUM_REGS, 7));
        cfg_write(junk_idx, {$urandom, $urandom});
        cfg_we <= 1'b0;
        key_loads++;
        repeat (REBUILD_WAIT) @(posedge clk);
    endtask

    // valid stays high across back-to-back transfers; gaps lower it
    task automatic send_block(logic [127:0] plain, bit literal, logic [127:0] cipher);
        aesbe_pkg::out_item_t exp_item;
        in_valid <= 1'b1;
        in_data  <= plain;
        do @(posedge clk); while (in_stall);
        exp_item = literal ? cipher : encrypt_block(plain);
        cipher_q = {cipher_q, exp_item};
        blocks_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [255:0] key;
        logic [1:0]   mode;
        int           phase_len;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        errors     = 0;
        blocks_sent = 0;
        blocks_seen = 0;
        key_loads  = 0;
        stall_left = 0;
        calm       = 1'b0;
        build_sbox();
        key_mode = aesbe_pkg::MODE_128;
        for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
        expand_schedule();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (REBUILD_WAIT) @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].rekey) begin
                in_valid <= 1'b0;
                load_key(dir_rows[i].mode, dir_rows[i].key);
            end
            send_block(dir_rows[i].plain, dir_rows[i].literal, dir_rows[i].cipher);
        end

        for (int ph = 0; ph < 9; ph++) begin
            in_valid <= 1'b0;
            mode = 2'($urandom_range(0, 3));
            key = {rand_word(), rand_word(), rand_word(), rand_word()};
            if (ph == 8) calm = 1'b1;
            load_key(mode, key);
            phase_len = 48;
            for (int n = 0; n < phase_len; n++) begin
                send_block({rand_word(), rand_word()}, 1'b0, 128'h0);
                if (ph == 3 && n == 20) begin
                    // hold off until the pipeline has emptied
                    in_valid <= 1'b0;
                    while (cipher_q.size() != 0) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (cipher_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Encrypted %0d blocks under %0d key loads (128/192/256-bit and mode three),",
                 blocks_seen, key_loads);
        $display("with random input gaps and output stalls; %0d errors.", errors);
        if (errors == 0 && cipher_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
